// ===== hw/rtl/fpalu_pkg.sv =====
// Shared types, operation codes and saturation helpers for the fixed-point ALU.
package fpalu_pkg;

    localparam int FRACTION_BITS_DEFAULT = 8;

    localparam int RAW_W = 32;
    localparam int NUM_W = 64;   // dividend and product magnitude width
    localparam int DEN_W = 33;   // doubled divisor width
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [RAW_W-1:0] RAW_MAX = 32'h7FFF_FFFF;
    localparam logic [RAW_W-1:0] RAW_MIN = 32'h8000_0000;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_OVF = 2'd1;
    localparam logic [1:0] STAT_DIV0 = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } func_t;

    typedef struct packed {
        logic [RAW_W-1:0] val;
        logic ovf;
    } sat_t;

    typedef struct packed {
        func_t func;
        logic [RAW_W-1:0] cres;    // result of the operations finished in the input stage
        logic cflag;
        logic [1:0] cstat;
        logic neg;
        logic dz;
        logic [RAW_W-1:0] ma;
        logic [RAW_W-1:0] mb;
        logic [NUM_W-1:0] mag;     // product magnitude, then rounded
        logic [NUM_W-1:0] num;     // dividend bits still to shift in
        logic [DEN_W-1:0] dd;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } pipe_t;

    function automatic sat_t sat33(input logic [RAW_W:0] v);
        sat_t s;
        s.ovf = v[RAW_W] ^ v[RAW_W-1];
        s.val = s.ovf ? (v[RAW_W] ? RAW_MIN : RAW_MAX) : v[RAW_W-1:0];
        return s;
    endfunction

    function automatic sat_t sat64(input logic [NUM_W-1:0] v);
        sat_t s;
        s.ovf = !((&v[NUM_W-1:RAW_W-1]) || !(|v[NUM_W-1:RAW_W-1]));
        s.val = s.ovf ? (v[NUM_W-1] ? RAW_MIN : RAW_MAX) : v[RAW_W-1:0];
        return s;
    endfunction

endpackage

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
// Signed fixed-point ALU on 32-bit raw words with FRACTION_BITS fraction bits.
// Every operation runs through the same pipeline of 68 registers: one input
// stage, one multiply stage, one rounding stage, 64 stages of a
// one-bit-per-stage restoring divider, and the saturating output register.
// A result is presented on m_tdata after its item has passed through these
// registers. One item is accepted every cycle; when the result side stalls, the
// whole pipeline holds. Multiply and divide round half away from zero;
// overflow saturates with status 1, divide by zero returns 0 with status 2.
module fixed_point_alu
    import fpalu_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] func, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] result, [32] flag, [34:33] status, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DIV_STEPS = NUM_W;
    localparam int NST = DIV_STEPS + 3;
    localparam logic [NUM_W-1:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

    logic [NST-1:0] v_reg, v_next;
    pipe_t p_reg [NST];
    pipe_t p_next [NST];
    logic m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic adv;

    assign adv = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    // input stage: results of the simple operations and operand magnitudes
    logic [RAW_W-1:0] sa, sb;
    func_t fin;
    sat_t s_add, s_sub, s_inc, s_dec, s_fi;
    logic lt, eqv;

    assign fin = func_t'(s_tdata[3:0]);
    assign sa = s_tdata[35:4];
    assign sb = s_tdata[67:36];

    always_comb begin
        s_add = sat33({sa[31], sa} + {sb[31], sb});
        s_sub = sat33({sa[31], sa} - {sb[31], sb});
        s_inc = sat33({sa[31], sa} + 33'd1);
        s_dec = sat33({sa[31], sa} - 33'd1);
        s_fi = sat64(NUM_W'($signed(sa)) << FRACTION_BITS);
        lt = $signed(sa) < $signed(sb);
        eqv = sa == sb;

        p_next[0] = '0;
        p_next[0].func = fin;
        p_next[0].neg = sa[31] ^ sb[31];
        p_next[0].dz = sb == '0;
        p_next[0].ma = sa[31] ? (~sa + 32'd1) : sa;
        p_next[0].mb = sb[31] ? (~sb + 32'd1) : sb;
        unique case (fin)
            OP_ADD: begin
                p_next[0].cres = s_add.val;
                p_next[0].cstat = s_add.ovf ? STAT_OVF : STAT_OK;
            end
            OP_SUB: begin
                p_next[0].cres = s_sub.val;
                p_next[0].cstat = s_sub.ovf ? STAT_OVF : STAT_OK;
            end
            OP_GT: p_next[0].cflag = !lt && !eqv;
            OP_LT: p_next[0].cflag = lt;
            OP_GE: p_next[0].cflag = !lt;
            OP_LE: p_next[0].cflag = lt || eqv;
            OP_EQ: p_next[0].cflag = eqv;
            OP_NE: p_next[0].cflag = !eqv;
            OP_MIN: p_next[0].cres = lt ? sa : sb;
            OP_MAX: p_next[0].cres = (!lt && !eqv) ? sa : sb;
            OP_INC: begin
                p_next[0].cres = s_inc.val;
                p_next[0].cstat = s_inc.ovf ? STAT_OVF : STAT_OK;
            end
            OP_DEC: begin
                p_next[0].cres = s_dec.val;
                p_next[0].cstat = s_dec.ovf ? STAT_OVF : STAT_OK;
            end
            OP_FROM_INT: begin
                p_next[0].cres = s_fi.val;
                p_next[0].cstat = s_fi.ovf ? STAT_OVF : STAT_OK;
            end
            OP_TO_INT: p_next[0].cres = RAW_W'($signed(sa) >>> FRACTION_BITS);
            default: p_next[0].cres = '0;   // mul and div finish at the end
        endcase
    end

    // multiply and set up the rounded divide: q = (2n + d) / (2d)
    always_comb begin
        p_next[1] = p_reg[0];
        p_next[1].mag = p_reg[0].ma * p_reg[0].mb;
        p_next[1].num = (NUM_W'(p_reg[0].ma) << (FRACTION_BITS + 1))
                        + NUM_W'(p_reg[0].mb);
        p_next[1].dd = {p_reg[0].mb, 1'b0};
        p_next[1].rem = '0;
        p_next[1].quo = '0;
    end

    always_comb begin
        p_next[2] = p_reg[1];
        p_next[2].mag = (p_reg[1].mag + HALF) >> FRACTION_BITS;
    end

    // restoring divider, one quotient bit per stage
    logic [DEN_W:0] rsh [DIV_STEPS];
    logic qbit [DIV_STEPS];
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_comb begin
            p_next[k+3] = p_reg[k+2];
            rsh[k] = {p_reg[k+2].rem, p_reg[k+2].num[NUM_W-1]};
            qbit[k] = rsh[k] >= {1'b0, p_reg[k+2].dd};
            p_next[k+3].rem = qbit[k] ? DEN_W'(rsh[k] - {1'b0, p_reg[k+2].dd})
                                      : rsh[k][DEN_W-1:0];
            p_next[k+3].num = p_reg[k+2].num << 1;
            p_next[k+3].quo = {p_reg[k+2].quo[NUM_W-2:0], qbit[k]};
        end
    end

    // saturate mul and div, select the output
    pipe_t pl;
    logic [NUM_W-1:0] fm, lim;
    logic fovf;
    logic [RAW_W-1:0] fval, fres;
    logic [1:0] fstat;
    always_comb begin
        pl = p_reg[NST-1];
        fm = (pl.func == OP_DIV) ? pl.quo : pl.mag;
        lim = pl.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        fovf = fm > lim;
        fval = pl.neg ? (~fm[RAW_W-1:0] + 32'd1) : fm[RAW_W-1:0];
        fres = pl.cres;
        fstat = pl.cstat;
        if (pl.func == OP_MUL || pl.func == OP_DIV) begin
            fres = fovf ? (pl.neg ? RAW_MIN : RAW_MAX) : fval;
            fstat = fovf ? STAT_OVF : STAT_OK;
            if (pl.func == OP_DIV && pl.dz) begin
                fres = '0;
                fstat = STAT_DIV0;
            end
        end
        m_data_next = {5'd0, fstat, pl.cflag, fres};
        v_next = {v_reg[NST-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= v_next;
            m_valid_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                p_reg[k] <= p_next[k];
            end
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the fixed-point ALU: directed table, then random items.
`timescale 1ns / 1ps

module tb_top;
    import fpalu_pkg::*;

    localparam int FB = FRACTION_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 1300;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0] status;
        logic flag;
        logic [31:0] result;
    } alu_out_t;

    typedef struct {
        func_t func;
        logic [31:0] a;
        logic [31:0] b;
        bit typed;
        alu_out_t want;
    } vec_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    alu_out_t pending_results[$];
    int mismatches;
    bit sending_done;
    longint cycles;

    fixed_point_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] clamp_raw(input longint v, inout logic [1:0] st);
        if (v > 64'sd2147483647) begin
            st = STAT_OVF;
            return RAW_MAX;
        end
        if (v < -64'sd2147483648) begin
            st = STAT_OVF;
            return RAW_MIN;
        end
        return v[31:0];
    endfunction

    function automatic alu_out_t alu_predict(input func_t f, input logic [31:0] ra,
                                             input logic [31:0] rb);
        longint a, b, p, q;
        logic [63:0] m, n, d;
        logic [1:0] st;
        alu_out_t o;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        st = STAT_OK;
        o = '0;
        case (f)
            OP_ADD: o.result = clamp_raw(a + b, st);
            OP_SUB: o.result = clamp_raw(a - b, st);
            OP_MUL: begin
                p = a * b;
                m = p < 0 ? -p : p;
                m = (m + (FB > 0 ? 64'd1 << (FB - 1) : 64'd0)) >> FB;
                q = p < 0 ? -longint'(m) : longint'(m);
                o.result = clamp_raw(q, st);
            end
            OP_DIV: begin
                if (b == 0) begin
                    st = STAT_DIV0;
                end else begin
                    n = (a < 0 ? -a : a) << FB;
                    d = b < 0 ? -b : b;
                    m = (2 * n + d) / (2 * d);
                    q = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
                    o.result = clamp_raw(q, st);
                end
            end
            OP_GT: o.flag = a > b;
            OP_LT: o.flag = a < b;
            OP_GE: o.flag = a >= b;
            OP_LE: o.flag = a <= b;
            OP_EQ: o.flag = a == b;
            OP_NE: o.flag = a != b;
            OP_MIN: o.result = a < b ? ra : rb;
            OP_MAX: o.result = a > b ? ra : rb;
            OP_INC: o.result = clamp_raw(a + 1, st);
            OP_DEC: o.result = clamp_raw(a - 1, st);
            OP_FROM_INT: o.result = clamp_raw(a * (64'sd1 <<< FB), st);
            default: o.result = $signed(ra) >>> FB;
        endcase
        o.status = st;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return RAW_MAX - $urandom_range(0, 3);
            1: return RAW_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 600) - 300;
            3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input func_t f, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, b, a, f};
        pending_results.push_back(alu_predict(f, a, b));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    vec_t table_rows[] = '{
        '{OP_ADD, RAW_MAX, 32'd1, 1, '{STAT_OVF, 1'b0, RAW_MAX}},
        '{OP_ADD, RAW_MIN, 32'hFFFF_FFFF, 1, '{STAT_OVF, 1'b0, RAW_MIN}},
        '{OP_SUB, RAW_MIN, 32'd1, 1, '{STAT_OVF, 1'b0, RAW_MIN}},
        '{OP_SUB, 32'd5, 32'd7, 1, '{STAT_OK, 1'b0, 32'hFFFF_FFFE}},
        '{OP_MUL, 32'h0000_0180, 32'h0000_0180, 0, '0},
        '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 0, '0},
        '{OP_MUL, RAW_MAX, RAW_MAX, 1, '{STAT_OVF, 1'b0, RAW_MAX}},
        '{OP_MUL, RAW_MIN, RAW_MAX, 1, '{STAT_OVF, 1'b0, RAW_MIN}},
        '{OP_DIV, 32'h0000_0100, 32'h0, 1, '{STAT_DIV0, 1'b0, 32'h0}},
        '{OP_DIV, RAW_MAX, 32'd1, 1, '{STAT_OVF, 1'b0, RAW_MAX}},
        '{OP_DIV, 32'h0000_0100, 32'h0000_0300, 0, '0},
        '{OP_DIV, 32'hFFFF_FF00, 32'h0000_0200, 0, '0},
        '{OP_GT, RAW_MAX, RAW_MIN, 1, '{STAT_OK, 1'b1, 32'h0}},
        '{OP_LT, RAW_MAX, RAW_MIN, 1, '{STAT_OK, 1'b0, 32'h0}},
        '{OP_GE, 32'd3, 32'd3, 1, '{STAT_OK, 1'b1, 32'h0}},
        '{OP_LE, 32'd4, 32'd3, 1, '{STAT_OK, 1'b0, 32'h0}},
        '{OP_EQ, RAW_MIN, RAW_MIN, 1, '{STAT_OK, 1'b1, 32'h0}},
        '{OP_NE, RAW_MIN, RAW_MIN, 1, '{STAT_OK, 1'b0, 32'h0}},
        '{OP_MIN, RAW_MAX, RAW_MIN, 1, '{STAT_OK, 1'b0, RAW_MIN}},
        '{OP_MAX, RAW_MAX, RAW_MIN, 1, '{STAT_OK, 1'b0, RAW_MAX}},
        '{OP_INC, RAW_MAX, 32'hFFFF_FFFF, 1, '{STAT_OVF, 1'b0, RAW_MAX}},
        '{OP_DEC, RAW_MIN, 32'h0, 1, '{STAT_OVF, 1'b0, RAW_MIN}},
        '{OP_FROM_INT, 32'h0080_0000, 32'h0, 1, '{STAT_OVF, 1'b0, RAW_MAX}},
        '{OP_FROM_INT, 32'hFFFF_FFFD, 32'h0, 1, '{STAT_OK, 1'b0, 32'hFFFF_FD00}},
        '{OP_TO_INT, 32'hFFFF_FF01, 32'h0, 1, '{STAT_OK, 1'b0, 32'hFFFF_FFFF}}
    };

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        sending_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (table_rows[i]) begin
            send_item(table_rows[i].func, table_rows[i].a, table_rows[i].b);
            // typed rows hold the expectation read straight off the spec
            if (table_rows[i].typed)
                pending_results[pending_results.size() - 1] = table_rows[i].want;
        end
        repeat (RANDOM_ITEMS) send_item(func_t'($urandom_range(0, 15)), pick_operand(),
                                        pick_operand());
        s_tvalid <= 1'b0;
        sending_done <= 1'b1;
    end

    // result side: random stalls, compare each item with the oldest prediction
    initial begin
        int stall;
        alu_out_t got, want;
        m_tready = 1'b0;
        mismatches = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[34:0];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %h", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: result %h/%h flag %b/%b status %0d/%0d",
                                     want.result, got.result, want.flag, got.flag,
                                     want.status, got.status);
                    end
                end
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) stall = 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end else if (aresetn) begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("fixed_point_alu verification failed");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && !m_tvalid) begin
            $display("fixed_point_alu verification clean");
        end else begin
            $display("fixed_point_alu verification failed");
        end
        $finish;
    end

endmodule
